>>> rtl/core/iff_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// iff_pkg
// Shared types, codes and sizes of the integer field formatter.
// ============================================================================
package iff_pkg;

    // Longest field that is emitted; longer fields are cut at this length.
    localparam int MAX_FIELD = 64;

    // Digit store: twenty digits cover a 64-bit magnitude in decimal.
    localparam int DIG_N  = 20;
    localparam int DIG_W  = DIG_N * 4;
    localparam int IDX_W  = $clog2(DIG_N);
    localparam int NDIG_W = $clog2(DIG_N + 1);

    // Zeros can reach the largest precision plus a full width of padding.
    localparam int ZCNT_W = $clog2(MAX_FIELD + 64);
    localparam int PCNT_W = $clog2(MAX_FIELD + 1);
    localparam int CALC_W = ZCNT_W + 1;

    // Argument and bit counter sizes follow from the fixed 64-bit argument.
    localparam int VAL_W  = 64;
    localparam int BITS_W = 7;

    // Descriptor queue depth.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Conversion kinds.
    localparam logic [1:0] KIND_SDEC = 2'd0;
    localparam logic [1:0] KIND_UDEC = 2'd1;
    localparam logic [1:0] KIND_LHEX = 2'd2;
    localparam logic [1:0] KIND_UHEX = 2'd3;

    // Length modifiers; every other code means a 32-bit argument.
    localparam logic [2:0] LMOD_HH = 3'd1;
    localparam logic [2:0] LMOD_H  = 3'd2;
    localparam logic [2:0] LMOD_L  = 3'd3;
    localparam logic [2:0] LMOD_LL = 3'd4;

    // Character codes.
    localparam logic [6:0] CH_SPACE = 7'd32;
    localparam logic [6:0] CH_PLUS  = 7'd43;
    localparam logic [6:0] CH_MINUS = 7'd45;
    localparam logic [6:0] CH_ZERO  = 7'd48;
    localparam logic [6:0] CH_UA    = 7'd65;
    localparam logic [6:0] CH_LA    = 7'd97;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONV,
        F_SIZE,
        F_LAYOUT
    } t_iff_fstate;

    typedef enum logic {
        B_IDLE,
        B_RUN
    } t_iff_bstate;

    // One laid-out field, ready to be emitted.
    typedef struct packed {
        logic [DIG_W-1:0]  digits;
        logic [NDIG_W-1:0] ndig;
        logic              has_sign;
        logic [6:0]        sign_code;
        logic [ZCNT_W-1:0] zeros;
        logic [PCNT_W-1:0] pad;
        logic [PCNT_W-1:0] len;
        logic              left;
        logic              upper;
    } t_iff_desc;

    typedef struct packed {
        logic      valid;
        t_iff_desc desc;
    } t_iff_push;

endpackage

>>> rtl/core/iff_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// iff_queue
// Short descriptor queue between the front and the back.
// ============================================================================
module iff_queue
    import iff_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_iff_push i_push,
    output logic      o_full,
    input  logic      i_pop,
    output logic      o_empty,
    output t_iff_desc o_data
);

    t_iff_desc         r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              w_do_push;
    logic              w_do_pop;

    assign o_full    = (r_count == QCNT_W'(QDEPTH));
    assign o_empty   = (r_count == '0);
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push.valid && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_push.desc;
        end
    end

endmodule

>>> rtl/core/iff_front.sv
`timescale 1ns / 1ps
// ============================================================================
// iff_front
// Accepts a request, reduces the argument, converts it to digits and lays
// out the field.
// ============================================================================
module iff_front
    import iff_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  logic [1:0]       i_req_type,
    input  logic [VAL_W-1:0] i_value,
    input  logic [2:0]       i_length_mod,
    input  logic             i_flag_left,
    input  logic             i_flag_plus,
    input  logic             i_flag_space,
    input  logic             i_flag_zero,
    input  logic [6:0]       i_width,
    input  logic [5:0]       i_precision,
    input  logic             i_q_full,
    output t_iff_push        o_push
);

    t_iff_fstate       r_state, n_state;
    logic              r_upper, n_upper;
    logic              r_left, n_left;
    logic              r_zero, n_zero;
    logic [6:0]        r_width, n_width;
    logic [5:0]        r_prec, n_prec;
    logic              r_has_sign, n_has_sign;
    logic [6:0]        r_sign_code, n_sign_code;
    logic [VAL_W-1:0]  r_mag, n_mag;
    logic [DIG_W-1:0]  r_bcd, n_bcd;
    logic [BITS_W-1:0] r_bit_cnt, n_bit_cnt;
    logic [NDIG_W-1:0] r_ndig, n_ndig;

    // Argument reduction at accept time.
    logic [VAL_W-1:0]  a_mask;
    logic [VAL_W-1:0]  a_val;
    logic              a_msb;
    logic              a_neg;
    logic [VAL_W-1:0]  a_mag;
    logic [VAL_W-1:0]  a_mag_al;
    logic [BITS_W-1:0] a_bits;
    logic              a_dec;

    // Layout arithmetic.
    logic [CALC_W-1:0] l_ndig;
    logic [CALC_W-1:0] l_prec;
    logic [CALC_W-1:0] l_zeros;
    logic [CALC_W-1:0] l_body;
    logic [CALC_W-1:0] l_wsat;
    logic [CALC_W-1:0] l_pad;
    logic [CALC_W-1:0] l_span;
    logic [CALC_W-1:0] l_len;
    logic              l_zpad;

    logic [DIG_W-1:0]  c_adj;

    assign o_busy = (r_state != F_IDLE);
    assign a_dec  = (i_req_type == KIND_SDEC) || (i_req_type == KIND_UDEC);

    always_comb begin
        unique case (i_length_mod)
            LMOD_HH: begin
                a_mask = VAL_W'(64'h0000_0000_0000_00FF);
                a_bits = BITS_W'(8);
                a_msb  = i_value[7];
            end
            LMOD_H: begin
                a_mask = VAL_W'(64'h0000_0000_0000_FFFF);
                a_bits = BITS_W'(16);
                a_msb  = i_value[15];
            end
            LMOD_L, LMOD_LL: begin
                a_mask = '1;
                a_bits = BITS_W'(64);
                a_msb  = i_value[63];
            end
            default: begin
                a_mask = VAL_W'(64'h0000_0000_FFFF_FFFF);
                a_bits = BITS_W'(32);
                a_msb  = i_value[31];
            end
        endcase
        a_val = i_value & a_mask;
        a_neg = (i_req_type == KIND_SDEC) && a_msb;
        a_mag = a_neg ? ((~a_val + 1'b1) & a_mask) : a_val;
        unique case (i_length_mod)
            LMOD_HH:         a_mag_al = {a_mag[7:0], 56'b0};
            LMOD_H:          a_mag_al = {a_mag[15:0], 48'b0};
            LMOD_L, LMOD_LL: a_mag_al = a_mag;
            default:         a_mag_al = {a_mag[31:0], 32'b0};
        endcase
    end

    // One double-dabble step: digits of five and above are raised by three.
    always_comb begin
        for (int i = 0; i < DIG_N; i++) begin
            c_adj[i*4 +: 4] = (r_bcd[i*4 +: 4] >= 4'd5) ? r_bcd[i*4 +: 4] + 4'd3
                                                        : r_bcd[i*4 +: 4];
        end
    end

    always_comb begin
        l_ndig  = CALC_W'(r_ndig);
        l_prec  = CALC_W'(r_prec);
        l_zeros = (l_prec > l_ndig) ? l_prec - l_ndig : '0;
        l_body  = l_zeros + l_ndig + CALC_W'(r_has_sign);
        l_wsat  = (CALC_W'(r_width) > CALC_W'(MAX_FIELD)) ? CALC_W'(MAX_FIELD)
                                                          : CALC_W'(r_width);
        l_pad   = (l_wsat > l_body) ? l_wsat - l_body : '0;
        l_span  = (l_wsat > l_body) ? l_wsat : l_body;
        l_len   = (l_span > CALC_W'(MAX_FIELD)) ? CALC_W'(MAX_FIELD) : l_span;
        l_zpad  = r_zero && !r_left && (r_prec == '0);
    end

    always_comb begin
        n_state     = r_state;
        n_upper     = r_upper;
        n_left      = r_left;
        n_zero      = r_zero;
        n_width     = r_width;
        n_prec      = r_prec;
        n_has_sign  = r_has_sign;
        n_sign_code = r_sign_code;
        n_mag       = r_mag;
        n_bcd       = r_bcd;
        n_bit_cnt   = r_bit_cnt;
        n_ndig      = r_ndig;
        o_push      = '0;

        unique case (r_state)
            F_IDLE: begin
                if (i_start) begin
                    n_upper    = (i_req_type == KIND_UHEX);
                    n_left     = i_flag_left;
                    n_zero     = i_flag_zero;
                    n_width    = i_width;
                    n_prec     = i_precision;
                    n_has_sign = (i_req_type == KIND_SDEC) &&
                                 (a_neg || i_flag_plus || i_flag_space);
                    if (a_neg) begin
                        n_sign_code = CH_MINUS;
                    end else if (i_flag_plus) begin
                        n_sign_code = CH_PLUS;
                    end else begin
                        n_sign_code = CH_SPACE;
                    end
                    n_mag     = a_mag_al;
                    n_bit_cnt = a_bits;
                    if (a_dec) begin
                        n_bcd   = '0;
                        n_state = F_CONV;
                    end else begin
                        n_bcd   = {{(DIG_W - VAL_W){1'b0}}, a_mag};
                        n_state = F_SIZE;
                    end
                end
            end
            F_CONV: begin
                n_bcd     = {c_adj[DIG_W-2:0], r_mag[VAL_W-1]};
                n_mag     = {r_mag[VAL_W-2:0], 1'b0};
                n_bit_cnt = r_bit_cnt - 1'b1;
                if (r_bit_cnt == BITS_W'(1)) begin
                    n_state = F_SIZE;
                end
            end
            F_SIZE: begin
                // Position of the highest nonzero digit; zero still has one digit.
                n_ndig = NDIG_W'(1);
                for (int i = 1; i < DIG_N; i++) begin
                    if (r_bcd[i*4 +: 4] != 4'd0) begin
                        n_ndig = NDIG_W'(i + 1);
                    end
                end
                n_state = F_LAYOUT;
            end
            F_LAYOUT: begin
                o_push.valid          = 1'b1;
                o_push.desc.digits    = r_bcd;
                o_push.desc.ndig      = r_ndig;
                o_push.desc.has_sign  = r_has_sign;
                o_push.desc.sign_code = r_sign_code;
                o_push.desc.zeros     = l_zpad ? ZCNT_W'(l_zeros + l_pad)
                                               : ZCNT_W'(l_zeros);
                o_push.desc.pad       = l_zpad ? '0 : PCNT_W'(l_pad);
                o_push.desc.len       = PCNT_W'(l_len);
                o_push.desc.left      = r_left;
                o_push.desc.upper     = r_upper;
                if (!i_q_full) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_upper     <= n_upper;
        r_left      <= n_left;
        r_zero      <= n_zero;
        r_width     <= n_width;
        r_prec      <= n_prec;
        r_has_sign  <= n_has_sign;
        r_sign_code <= n_sign_code;
        r_mag       <= n_mag;
        r_bcd       <= n_bcd;
        r_bit_cnt   <= n_bit_cnt;
        r_ndig      <= n_ndig;
    end

endmodule

>>> rtl/core/iff_back.sv
`timescale 1ns / 1ps
// ============================================================================
// iff_back
// Pops laid-out queue fields and emits one character per cycle within a field.
// ============================================================================
module iff_back
    import iff_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_iff_desc  i_q_data,
    output logic       o_pop,
    output logic       o_strobe,
    output logic [6:0] o_char_code,
    output logic       o_last_char
);

    t_iff_bstate       r_state, n_state;
    logic [DIG_W-1:0]  r_digits, n_digits;
    logic [NDIG_W-1:0] r_dig_cnt, n_dig_cnt;
    logic [ZCNT_W-1:0] r_zero_cnt, n_zero_cnt;
    logic [PCNT_W-1:0] r_pad_cnt, n_pad_cnt;
    logic [PCNT_W-1:0] r_remain, n_remain;
    logic              r_sign_pend, n_sign_pend;
    logic [6:0]        r_sign_code, n_sign_code;
    logic              r_left, n_left;
    logic              r_upper, n_upper;

    logic [IDX_W-1:0]  w_idx;
    logic [3:0]        w_digit;
    logic [6:0]        w_digit_ch;
    logic [6:0]        w_char;

    assign w_idx      = IDX_W'(r_dig_cnt - 1'b1);
    assign w_digit    = r_digits[w_idx*4 +: 4];
    assign w_digit_ch = (w_digit < 4'd10) ? CH_ZERO + {3'b0, w_digit}
                      : (r_upper ? CH_UA : CH_LA) + {3'b0, w_digit} - 7'd10;

    assign o_pop       = (r_state == B_IDLE) && !i_q_empty;
    assign o_strobe    = (r_state == B_RUN);
    assign o_char_code = w_char;
    assign o_last_char = (r_state == B_RUN) && (r_remain == PCNT_W'(1));

    always_comb begin
        n_state     = r_state;
        n_digits    = r_digits;
        n_dig_cnt   = r_dig_cnt;
        n_zero_cnt  = r_zero_cnt;
        n_pad_cnt   = r_pad_cnt;
        n_remain    = r_remain;
        n_sign_pend = r_sign_pend;
        n_sign_code = r_sign_code;
        n_left      = r_left;
        n_upper     = r_upper;
        w_char      = CH_SPACE;

        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    n_digits    = i_q_data.digits;
                    n_dig_cnt   = i_q_data.ndig;
                    n_zero_cnt  = i_q_data.zeros;
                    n_pad_cnt   = i_q_data.pad;
                    n_remain    = i_q_data.len;
                    n_sign_pend = i_q_data.has_sign;
                    n_sign_code = i_q_data.sign_code;
                    n_left      = i_q_data.left;
                    n_upper     = i_q_data.upper;
                    n_state     = B_RUN;
                end
            end
            B_RUN: begin
                // Order: leading spaces, sign, zeros, digits, trailing spaces.
                if (!r_left && (r_pad_cnt != '0)) begin
                    w_char    = CH_SPACE;
                    n_pad_cnt = r_pad_cnt - 1'b1;
                end else if (r_sign_pend) begin
                    w_char      = r_sign_code;
                    n_sign_pend = 1'b0;
                end else if (r_zero_cnt != '0) begin
                    w_char     = CH_ZERO;
                    n_zero_cnt = r_zero_cnt - 1'b1;
                end else if (r_dig_cnt != '0) begin
                    w_char    = w_digit_ch;
                    n_dig_cnt = r_dig_cnt - 1'b1;
                end else begin
                    w_char    = CH_SPACE;
                    n_pad_cnt = r_pad_cnt - 1'b1;
                end
                n_remain = r_remain - 1'b1;
                if (r_remain == PCNT_W'(1)) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digits    <= n_digits;
        r_dig_cnt   <= n_dig_cnt;
        r_zero_cnt  <= n_zero_cnt;
        r_pad_cnt   <= n_pad_cnt;
        r_remain    <= n_remain;
        r_sign_pend <= n_sign_pend;
        r_sign_code <= n_sign_code;
        r_left      <= n_left;
        r_upper     <= n_upper;
    end

endmodule

>>> rtl/core/integer_field_formatter.sv
`timescale 1ns / 1ps
// ============================================================================
// integer_field_formatter
// Formats one integer conversion (signed or unsigned decimal, lower or
// upper hex) into a stream of ASCII characters, one per cycle within a field.
// ============================================================================
//
//  Channel   Handshake            Payload
//  --------  -------------------  ------------------------------------------
//  request   start / busy         i_req_type, i_value, i_length_mod, flags,
//                                 i_width, i_precision
//  result    o_strobe (1 cycle)   o_char_code, o_last_char
//
// A request is taken at a rising edge with start high and busy low. The
// front reduces the argument to the size its length modifier selects and
// converts it: decimal runs a shift-and-add-three converter one argument
// bit per cycle, hex needs no conversion. A size step then finds the digit
// count and a layout step lays out the field; busy stays high until the
// field is pushed, which waits while the descriptor queue is full.
// The back emits one character per cycle while a field runs and spends an
// idle step loading each field, in which no strobe comes; the sustained
// rate is set by the slower of the two sides.
// Reset is synchronous and active low; it empties the queue and returns
// both sides to idle. The receiver cannot stall: each strobe is one
// character, taken at the edge that ends its cycle.
//
module integer_field_formatter
    import iff_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_req_type,
    input  logic [VAL_W-1:0] i_value,
    input  logic [2:0]       i_length_mod,
    input  logic             i_flag_left,
    input  logic             i_flag_plus,
    input  logic             i_flag_space,
    input  logic             i_flag_zero,
    input  logic [6:0]       i_width,
    input  logic [5:0]       i_precision,
    output logic             o_strobe,
    output logic [6:0]       o_char_code,
    output logic             o_last_char
);

    // Front to queue: a laid-out field and the queue's back-pressure.
    t_iff_push w_push;
    logic      w_q_full;

    // Queue to back.
    logic      w_q_empty;
    logic      w_pop;
    t_iff_desc w_q_data;

    iff_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .o_busy       (busy),
        .i_req_type   (i_req_type),
        .i_value      (i_value),
        .i_length_mod (i_length_mod),
        .i_flag_left  (i_flag_left),
        .i_flag_plus  (i_flag_plus),
        .i_flag_space (i_flag_space),
        .i_flag_zero  (i_flag_zero),
        .i_width      (i_width),
        .i_precision  (i_precision),
        .i_q_full     (w_q_full),
        .o_push       (w_push)
    );

    // The queue lets the front convert the next request while the back is
    // still emitting a long field.
    iff_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_empty (w_q_empty),
        .o_data  (w_q_data)
    );

    iff_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_q_empty),
        .i_q_data    (w_q_data),
        .o_pop       (w_pop),
        .o_strobe    (o_strobe),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char)
    );

endmodule

>>> rtl/core/iff_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// iff_checker
// Port-level checks of the integer field formatter, bound to the top level.
// ============================================================================
module iff_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_strobe,
    input logic [6:0] o_char_code,
    input logic       o_last_char
);

    // A taken request always keeps the front occupied for the next cycle.
    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after a request was taken");

    // Reset leaves both sides idle.
    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_strobe && !busy))
        else $error("block not idle after reset");

    a_last_needs_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_char |-> o_strobe)
        else $error("last-character mark without a strobe");

    // The characters of one field come out without gaps.
    a_field_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_char) |=> o_strobe)
        else $error("gap inside a field");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((o_char_code >= 7'd32) && (o_char_code <= 7'd102)))
        else $error("character outside the formatter's set");

endmodule

bind integer_field_formatter iff_checker u_iff_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_strobe    (o_strobe),
    .o_char_code (o_char_code),
    .o_last_char (o_last_char)
);

>>> test/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the integer field formatter. A directed table covers
// the extremes of the argument, every conversion kind and length modifier,
// and the flag interactions. A long run of random requests follows, with
// random sender gaps. Every character the block emits is checked, in order,
// against written-out text or a behavioral formatter kept inside the bench.
// ============================================================================
module testbench;
    import iff_pkg::*;

    // Length modifier codes the package does not name: no modifier, and
    // undefined codes that must behave like no modifier.
    localparam logic [2:0] LMOD_NONE = 3'd0;
    localparam logic [2:0] LMOD_RSV  = 3'd5;
    localparam logic [2:0] LMOD_BAD  = 3'd7;

    // Flag bits of a request, in the order left, plus, space, zero.
    localparam logic [3:0] FL_NONE  = 4'b0000;
    localparam logic [3:0] FL_LEFT  = 4'b1000;
    localparam logic [3:0] FL_PLUS  = 4'b0100;
    localparam logic [3:0] FL_SPACE = 4'b0010;
    localparam logic [3:0] FL_ZERO  = 4'b0001;

    localparam int N_DIR        = 25;
    localparam int N_RANDOM     = 445;
    localparam int N_CALM       = 60;   // final random requests sent with no gaps
    localparam int DRAIN_CYCLES = 150;  // longest decimal conversion plus a full field

    typedef struct packed {
        logic [1:0]       kind;
        logic [VAL_W-1:0] value;
        logic [2:0]       lmod;
        logic [3:0]       flags;
        logic [6:0]       width;
        logic [5:0]       prec;
    } t_fmt_req;

    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } t_fmt_char;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [1:0]       i_req_type = '0;
    logic [VAL_W-1:0] i_value = '0;
    logic [2:0]       i_length_mod = '0;
    logic             i_flag_left = 1'b0;
    logic             i_flag_plus = 1'b0;
    logic             i_flag_space = 1'b0;
    logic             i_flag_zero = 1'b0;
    logic [6:0]       i_width = '0;
    logic [5:0]       i_precision = '0;
    logic             o_strobe;
    logic [6:0]       o_char_code;
    logic             o_last_char;

    // Characters still owed by the block, oldest first.
    t_fmt_char pending_chars [$];
    int        mismatch_count = 0;

    integer_field_formatter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req_type  (i_req_type),
        .i_value     (i_value),
        .i_length_mod(i_length_mod),
        .i_flag_left (i_flag_left),
        .i_flag_plus (i_flag_plus),
        .i_flag_space(i_flag_space),
        .i_flag_zero (i_flag_zero),
        .i_width     (i_width),
        .i_precision (i_precision),
        .o_strobe    (o_strobe),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Directed requests. Where the formatted text is obvious it is written
    // out in dir_text at the row's index; an empty string means the
    // behavioral formatter decides what the block must print.
    t_fmt_req dir_rows [N_DIR] = '{
        '{KIND_SDEC, 64'h0,                  LMOD_NONE, FL_NONE,  7'd0,   6'd0},
        '{KIND_SDEC, 64'hFFFF_FFFF_8000_0000, LMOD_NONE, FL_NONE,  7'd0,   6'd0},
        '{KIND_SDEC, 64'h7FFF_FFFF_FFFF_FFFF, LMOD_L,    FL_NONE,  7'd0,   6'd0},
        '{KIND_SDEC, 64'h8000_0000_0000_0000, LMOD_LL,   FL_NONE,  7'd0,   6'd0},
        '{KIND_UDEC, 64'hFFFF_FFFF_FFFF_FFFF, LMOD_L,    FL_NONE,  7'd0,   6'd0},
        '{KIND_LHEX, 64'hFFFF_FFFF_FFFF_FFFF, LMOD_LL,   FL_NONE,  7'd0,   6'd0},
        '{KIND_UHEX, 64'h0123_4567_DEAD_BEEF, LMOD_NONE, FL_NONE,  7'd0,   6'd0},
        '{KIND_SDEC, 64'h80,                 LMOD_HH,   FL_NONE,  7'd0,   6'd0},
        '{KIND_SDEC, 64'hFFFF_FF7F,          LMOD_HH,   FL_NONE,  7'd0,   6'd0},
        '{KIND_SDEC, 64'hFFFF,               LMOD_H,    FL_NONE,  7'd0,   6'd0},
        '{KIND_SDEC, 64'h1_FFFF_FFFF,        LMOD_BAD,  FL_NONE,  7'd0,   6'd0},
        '{KIND_UDEC, 64'hFFFF_FFFF_FFFF_FFFF, LMOD_RSV,  FL_NONE,  7'd0,   6'd0},
        '{KIND_UDEC, 64'd5,                  LMOD_NONE, FL_PLUS | FL_SPACE, 7'd0, 6'd0},
        '{KIND_LHEX, 64'hAB,                 LMOD_NONE, FL_PLUS,  7'd0,   6'd0},
        '{KIND_SDEC, 64'd5,                  LMOD_NONE, FL_PLUS | FL_SPACE, 7'd0, 6'd0},
        '{KIND_SDEC, 64'd5,                  LMOD_NONE, FL_SPACE, 7'd0,   6'd0},
        '{KIND_SDEC, 64'hFFFF_FFD6,          LMOD_NONE, FL_ZERO,  7'd5,   6'd0},
        '{KIND_SDEC, 64'd42,                 LMOD_NONE, FL_LEFT | FL_ZERO, 7'd5, 6'd0},
        '{KIND_SDEC, 64'd42,                 LMOD_NONE, FL_ZERO,  7'd6,   6'd3},
        '{KIND_UDEC, 64'd0,                  LMOD_NONE, FL_NONE,  7'd0,   6'd5},
        '{KIND_UHEX, 64'h1234_ABCD,          LMOD_H,    FL_NONE,  7'd0,   6'd0},
        '{KIND_SDEC, 64'd1,                  LMOD_NONE, FL_NONE,  7'd127, 6'd0},
        '{KIND_SDEC, 64'hFFFF_FFFF_FFFF_FFFF, LMOD_LL,   FL_NONE,  7'd0,   6'd63},
        '{KIND_UDEC, 64'hFFFF_FFFF_FFFF_FFFF, LMOD_LL,   FL_ZERO,  7'd100, 6'd0},
        '{KIND_LHEX, 64'hFFFF,               LMOD_NONE, FL_LEFT,  7'd64,  6'd0}
    };

    string dir_text [N_DIR] = '{
        "0", "-2147483648", "9223372036854775807", "-9223372036854775808",
        "18446744073709551615", "ffffffffffffffff", "DEADBEEF", "-128", "127",
        "-1", "-1", "4294967295", "5", "ab", "+5", " 5", "-0042", "42   ",
        "   042", "00000", "ABCD", "", "", "", ""
    };

    // Appends one formatted field to the expected characters, cutting it at
    // the field cap and marking its final character.
    function automatic void queue_field(input logic [6:0] field [$]);
        t_fmt_char c;
        while (field.size() > MAX_FIELD)
            void'(field.pop_back());
        foreach (field[k]) begin
            c.code = field[k];
            c.last = (k == field.size() - 1);
            pending_chars.push_back(c);
        end
    endfunction

    // Behavioral formatter: reduces the argument to the modifier's size,
    // converts it, then lays out sign, zeros, digits and padding.
    function automatic void format_request(input t_fmt_req r);
        int         bits;
        int         d;
        int         zeros;
        int         body;
        int         padn;
        int         wid;
        logic       left_al;
        logic [63:0] mask;
        logic [63:0] v;
        logic [63:0] mag;
        logic [63:0] base;
        logic [6:0] sign_ch;
        logic [6:0] digs [$];
        logic [6:0] field [$];
        left_al = |(r.flags & FL_LEFT);
        case (r.lmod)
            LMOD_HH:         bits = 8;
            LMOD_H:          bits = 16;
            LMOD_L, LMOD_LL: bits = 64;
            default:         bits = 32;
        endcase
        mask = (bits == 64) ? '1 : ((64'd1 << bits) - 64'd1);
        v = r.value & mask;
        mag = v;
        sign_ch = '0;
        // Only signed decimal carries a sign; plus beats space.
        if (r.kind == KIND_SDEC) begin
            if (v[bits-1]) begin
                mag = (~v + 64'd1) & mask;
                sign_ch = CH_MINUS;
            end else if (|(r.flags & FL_PLUS)) begin
                sign_ch = CH_PLUS;
            end else if (|(r.flags & FL_SPACE)) begin
                sign_ch = CH_SPACE;
            end
        end
        base = (r.kind == KIND_LHEX || r.kind == KIND_UHEX) ? 64'd16 : 64'd10;
        do begin
            d = int'(mag % base);
            if (d < 10)
                digs.push_front(CH_ZERO + 7'(d));
            else
                digs.push_front(((r.kind == KIND_UHEX) ? CH_UA : CH_LA) + 7'(d - 10));
            mag = mag / base;
        end while (mag != 0);
        zeros = (int'(r.prec) > digs.size()) ? int'(r.prec) - digs.size() : 0;
        body = ((sign_ch != '0) ? 1 : 0) + zeros + digs.size();
        wid = (int'(r.width) > MAX_FIELD) ? MAX_FIELD : int'(r.width);
        padn = (wid > body) ? wid - body : 0;
        // Zero padding only applies without a precision and right-aligned.
        if (|(r.flags & FL_ZERO) && !left_al && r.prec == '0) begin
            zeros += padn;
            padn = 0;
        end
        if (!left_al)
            repeat (padn) field.push_back(CH_SPACE);
        if (sign_ch != '0)
            field.push_back(sign_ch);
        repeat (zeros) field.push_back(CH_ZERO);
        foreach (digs[k])
            field.push_back(digs[k]);
        if (left_al)
            repeat (padn) field.push_back(CH_SPACE);
        queue_field(field);
    endfunction

    task automatic flag_error(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // Presents one request and holds start high until an edge with busy low
    // takes it. The caller is already at a rising edge. The expected text is
    // queued at that edge; the first character can only come cycles later.
    task automatic send_request(input t_fmt_req r, input string text);
        logic [6:0] field [$];
        start        <= 1'b1;
        i_req_type   <= r.kind;
        i_value      <= r.value;
        i_length_mod <= r.lmod;
        {i_flag_left, i_flag_plus, i_flag_space, i_flag_zero} <= r.flags;
        i_width      <= r.width;
        i_precision  <= r.prec;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (text.len() > 0) begin
            for (int k = 0; k < text.len(); k++)
                field.push_back(7'(text[k]));
            queue_field(field);
        end else begin
            format_request(r);
        end
    endtask

    // Sender gap: with some chance, start drops for a burst of random length.
    // When start is to stay high for the next request, it is left untouched
    // here so that it sees only one assignment in this time step.
    task automatic sender_pause(input bit allow);
        if (allow && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // Character checker. Values are read at the rising edge, before the
    // block's own updates for that edge land.
    always @(posedge i_clk) begin
        t_fmt_char want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_chars.size() == 0) begin
                flag_error($sformatf("character 0x%02h with no request waiting", o_char_code));
            end else begin
                want = pending_chars.pop_front();
                if (o_char_code !== want.code)
                    flag_error($sformatf("char_code 0x%02h, expected 0x%02h",
                                         o_char_code, want.code));
                if (o_last_char !== want.last)
                    flag_error($sformatf("last_char %b, expected %b on char 0x%02h",
                                         o_last_char, want.last, want.code));
            end
        end
    end

    initial begin
        t_fmt_req req;
        bit       gaps_on;
        int       sh;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < N_DIR; k++) begin
            send_request(dir_rows[k], dir_text[k]);
            sender_pause(1'b1);
        end

        // Random requests. Values lean toward the interesting places: zero,
        // small numbers, sign boundaries of every size, and all ones. Widths
        // and precisions are mostly modest, with the occasional large one.
        for (int n = 0; n < N_RANDOM; n++) begin
            req.kind = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 5))
                0: req.value = 64'($urandom_range(0, 20));
                1: begin
                    sh = $urandom_range(0, 63);
                    req.value = (64'd1 << sh) - 64'($urandom_range(0, 1));
                end
                2: req.value = '1 - 64'($urandom_range(0, 3));
                default: req.value = {$urandom, $urandom};
            endcase
            req.lmod = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                   : 3'($urandom_range(0, 4));
            req.flags = 4'($urandom_range(0, 15));
            req.width = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                                    : 7'($urandom_range(0, 24));
            if ($urandom_range(0, 7) == 0)
                req.prec = 6'($urandom_range(0, 63));
            else if ($urandom_range(0, 1) == 0)
                req.prec = '0;
            else
                req.prec = 6'($urandom_range(1, 12));
            send_request(req, "");
            // Gaps come and go in stretches, and the closing stretch runs
            // back to back.
            gaps_on = ((n / 40) % 3 != 2) && (n < N_RANDOM - N_CALM);
            sender_pause(gaps_on);
        end
        start <= 1'b0;

        while (pending_chars.size() != 0)
            @(posedge i_clk);
        // Stay a while longer so stray characters are caught.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

>>> integer_field_formatter.f
rtl/core/iff_pkg.sv
rtl/core/iff_queue.sv
rtl/core/iff_front.sv
rtl/core/iff_back.sv
rtl/core/integer_field_formatter.sv
rtl/core/iff_checker.sv
test/testbench.sv
